/* src/nph_pkg.sv */
// Package for the normalised pixel histogram: item types, register map,
// divider control types and fixed constants. No dependencies.
package nph_pkg;

    localparam int PIX_W     = 8;
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 17;
    localparam int FRAC_BITS = 16;
    localparam int BINS_W    = 7;
    localparam int RANGE_W   = 9;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int QMSB_W    = 5;

    // register indexes, taken from paddr[2]
    localparam logic REG_BIN_COUNT = 1'b0;
    localparam logic REG_RANGE_END = 1'b1;

    localparam logic [BINS_W-1:0]  BIN_COUNT_RESET = 7'd8;
    localparam logic [RANGE_W-1:0] RANGE_END_RESET = 9'd256;

    // highest quotient bit for the two divisions that share the divider
    localparam logic [QMSB_W-1:0] QMSB_BIN = 5'd5;
    localparam logic [QMSB_W-1:0] QMSB_VAL = 5'd16;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic [VAL_W-1:0] bin_value;
        logic             last_bin;
    } bin_out_t;

    typedef struct packed {
        logic              start;
        logic [QMSB_W-1:0] qmsb;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quo;
    } div_rsp_t;

endpackage

/* src/nph_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nph_pkg (div_req_t, div_rsp_t, VAL_W).
module nph_div
    import nph_pkg::*;
#(
    parameter int NW = 41,
    parameter int DW = 24
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  div_req_t      req,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output div_rsp_t      rsp
);

    logic [NW-1:0]     rem_reg;
    logic [NW-1:0]     den_sh_reg;
    logic [VAL_W-1:0]  quo_reg;
    logic [QMSB_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    // caller guarantees num < den << (qmsb + 1)
    assign fits = (rem_reg >= den_sh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            // flag the cycle after the last quotient bit
            done_reg <= busy_reg && !req.start && (step_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= req.qmsb;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg    <= num;
            den_sh_reg <= NW'(den) << req.qmsb;
            quo_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - den_sh_reg;
            end
            quo_reg    <= {quo_reg[VAL_W-2:0], fits};
            den_sh_reg <= den_sh_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* src/normalized_pixel_histogram.sv */
// Normalised pixel histogram: top level with bin count memory, sequencer
// and configuration registers. Depends on nph_pkg and nph_div.
//
// Use:
//   pix channel (pix_valid / pix_stall / pix_data) takes one pixel item and
//   its last_pixel mark. bin channel (bin_valid / bin_stall / bin_data)
//   gives one item per bin when an image ends: index, share of counted
//   pixels as unsigned Q1.16, and a last_bin mark on the final bin.
//   APB registers: bin_count at 0x0, range_end at 0x4; write only while idle.
// Pixel and bin handling:
//   A pixel that falls outside the bins is dropped as it is taken. A counted
//   pixel runs the bin division (one quotient bit a cycle in the shared
//   divider), then a read and a write of the count memory; the next pixel
//   waits until it is done. Each bin is read and then its share is worked
//   out by the 17-step share division, skipped when nothing was counted.
//   No pixel is taken while bins are being emitted.
// Reset:
//   Registers return to 8 bins over 0..255, all counts read as zero
//   (per-entry valid bits), no clearing pass is needed.
// Stall:
//   A stalled bin item holds in the output register; the next bin's read
//   and division go on behind it. After the last bin is loaded the block
//   takes pixels again even if that item is still waiting.
module normalized_pixel_histogram
    import nph_pkg::*;
#(
    parameter int MAX_BINS   = 64,
    parameter int COUNT_BITS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    // pixel items
    input  logic               pix_valid,
    output logic               pix_stall,
    input  pix_in_t            pix_data,
    // bin items
    output logic               bin_valid,
    input  logic               bin_stall,
    output bin_out_t           bin_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int DW = (COUNT_BITS > RANGE_W) ? COUNT_BITS : RANGE_W;
    localparam int NW = DW + VAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIN,
        S_UPD,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_DIV,
        S_EMIT_PUT
    } state_t;

    state_t                 state_reg;
    logic [BINS_W-1:0]      bin_count_reg;
    logic [RANGE_W-1:0]     range_end_reg;
    logic [COUNT_BITS-1:0]  total_reg;
    logic [MAX_BINS-1:0]    valid_reg;
    logic                   rd_valid_reg;
    logic                   last_reg;
    logic [IW-1:0]          bin_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [VAL_W-1:0]       val_reg;
    logic                   bin_valid_reg;
    bin_out_t               bin_out_reg;

    // count memory, one entry per bin
    logic [COUNT_BITS-1:0]  mem [MAX_BINS];
    logic [COUNT_BITS-1:0]  mem_rdata_reg;
    logic [IW-1:0]          mem_raddr;
    logic                   mem_we;
    logic [COUNT_BITS-1:0]  mem_wdata;

    logic [BINS_W-1:0]      nbins;
    logic                   pix_take;
    logic                   keep;
    logic [14:0]            prod;
    logic [COUNT_BITS-1:0]  cur;
    logic                   emit_last;
    logic                   out_free;
    logic                   cfg_wr;

    div_req_t               div_req;
    div_rsp_t               div_rsp;
    logic [NW-1:0]          div_num;
    logic [DW-1:0]          div_den;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= BIN_COUNT_RESET;
            range_end_reg <= RANGE_END_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_BIN_COUNT: bin_count_reg <= pwdata[BINS_W-1:0];
                REG_RANGE_END: range_end_reg <= pwdata[RANGE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BIN_COUNT: prdata = PDATA_W'(bin_count_reg);
            REG_RANGE_END: prdata = PDATA_W'(range_end_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath decisions
    // ---------------------------------------------------------------
    // clamp the bin count to the memory depth
    assign nbins = (bin_count_reg > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bin_count_reg;

    assign pix_stall = (state_reg != S_IDLE);
    assign pix_take  = pix_valid && !pix_stall;

    // pixel*n/range < n exactly when pixel < range; a zero range drops all
    assign keep = (nbins != '0) && ({1'b0, pix_data.pixel} < range_end_reg);
    assign prod = 15'(pix_data.pixel) * 15'(nbins);

    // an entry never written since the last clear reads as zero
    assign cur       = rd_valid_reg ? mem_rdata_reg : '0;
    assign emit_last = (({1'b0, idx_reg} + 7'd1) == nbins);
    assign out_free  = !bin_valid_reg || !bin_stall;

    // shared divider: bin number while idle, bin share during emission
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.qmsb  = QMSB_VAL;
        div_num       = NW'({cur, {FRAC_BITS{1'b0}}});
        div_den       = DW'(total_reg);
        if (state_reg == S_IDLE)
        begin
            div_req.start = pix_take && keep;
            div_req.qmsb  = QMSB_BIN;
            div_num       = NW'(prod);
            div_den       = DW'(range_end_reg);
        end
        else if (state_reg == S_EMIT_LD)
        begin
            div_req.start = (total_reg != '0);
        end
    end

    nph_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // Count memory: read address from the divider or the emit index,
    // write back the incremented count
    // ---------------------------------------------------------------
    assign mem_raddr = (state_reg == S_BIN) ? div_rsp.quo[IW-1:0] : idx_reg[IW-1:0];
    assign mem_we    = (state_reg == S_UPD);
    assign mem_wdata = (cur == '1) ? cur : cur + 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[bin_reg] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            last_reg      <= 1'b0;
            bin_reg       <= '0;
            idx_reg       <= '0;
            val_reg       <= '0;
            bin_valid_reg <= 1'b0;
            bin_out_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[mem_raddr];
            // drop a taken item; S_EMIT_PUT reloads the register itself
            if (bin_valid_reg && !bin_stall && (state_reg != S_EMIT_PUT))
            begin
                bin_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pix_take)
                    begin
                        last_reg <= pix_data.last_pixel;
                        idx_reg  <= '0;
                        if (keep)
                        begin
                            state_reg <= S_BIN;
                        end
                        else if (pix_data.last_pixel)
                        begin
                            if (nbins == '0)
                            begin
                                // nothing to emit: just drop the image
                                valid_reg <= '0;
                                total_reg <= '0;
                            end
                            else
                            begin
                                state_reg <= S_EMIT_RD;
                            end
                        end
                    end
                end
                S_BIN:
                begin
                    if (div_rsp.done)
                    begin
                        bin_reg   <= div_rsp.quo[IW-1:0];
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    valid_reg[bin_reg] <= 1'b1;
                    if (total_reg != '1)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                    state_reg <= last_reg ? S_EMIT_RD : S_IDLE;
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    if (total_reg == '0)
                    begin
                        val_reg   <= '0;
                        state_reg <= S_EMIT_PUT;
                    end
                    else
                    begin
                        state_reg <= S_EMIT_DIV;
                    end
                end
                S_EMIT_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        val_reg   <= div_rsp.quo;
                        state_reg <= S_EMIT_PUT;
                    end
                end
                S_EMIT_PUT:
                begin
                    if (out_free)
                    begin
                        bin_valid_reg         <= 1'b1;
                        bin_out_reg.bin_index <= idx_reg;
                        bin_out_reg.bin_value <= val_reg;
                        bin_out_reg.last_bin  <= emit_last;
                        if (emit_last)
                        begin
                            // image done: clear every bin, including unused ones
                            valid_reg <= '0;
                            total_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign bin_valid = bin_valid_reg;
    assign bin_data  = bin_out_reg;

endmodule

/* src/nph_chk.sv */
// Port-level assertions for the normalised pixel histogram, bound to the
// top level. Depends on nph_pkg (bin_out_t).
module nph_chk
    import nph_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     pix_stall,
    input logic     bin_valid,
    input logic     bin_stall,
    input bin_out_t bin_data
);

    // hold a stalled bin item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && bin_stall |=> bin_valid && $stable(bin_data))
        else $error("stalled bin item changed");

    // a share never exceeds one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && bin_data.bin_value[VAL_W-1] |-> bin_data.bin_value[VAL_W-2:0] == '0)
        else $error("bin share above one");

    // bins come out in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && !bin_stall && !bin_data.last_bin
        |=> !bin_valid || bin_data.bin_index == IDX_W'($past(bin_data.bin_index) + 1'b1))
        else $error("bin index out of order");

    // no pixel is taken while an image is still being emitted
    a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid && !bin_data.last_bin |-> pix_stall)
        else $error("pixel taken during emission");

endmodule

bind normalized_pixel_histogram nph_chk u_nph_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_stall (pix_stall),
    .bin_valid (bin_valid),
    .bin_stall (bin_stall),
    .bin_data  (bin_data)
);

/* bench/testbench.sv */
// Self-checking bench for normalized_pixel_histogram: directed plan, then random images.
// Depends on nph_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import nph_pkg::*;

    localparam int MAX_BINS     = 64;
    localparam int COUNT_BITS   = 24;
    localparam int RANDOM_ITEMS = 200;
    // the last stretch of random items runs with no idling on either side
    localparam int CALM_ITEMS   = 30;
    // covers a counted pixel and a bin share division
    localparam int SETTLE       = 50;
    localparam int LIMIT        = 2500000;
    localparam int SHARE_ONE    = 65536;
    localparam int PLAN_LEN     = 32;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_SET_BINS,
        STEP_SET_RANGE
    } step_kind_t;

    // One directed step. For pixel steps value is the pixel; for register
    // steps it is the value written. A typed share replaces the predicted
    // share of the named bin where it can be worked out by hand.
    typedef struct packed {
        step_kind_t          kind;
        logic [8:0]          value;
        logic                last;
        logic                typed;
        logic [IDX_W-1:0]    typed_bin;
        logic [VAL_W-1:0]    typed_share;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               pix_valid = 1'b0;
    logic               pix_stall;
    pix_in_t            pix_data = '0;
    logic               bin_valid;
    logic               bin_stall = 1'b0;
    bin_out_t           bin_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // predictor state: own copy of the registers and the bin counts
    logic [BINS_W-1:0]     bins_setting = BIN_COUNT_RESET;
    logic [RANGE_W-1:0]    range_setting = RANGE_END_RESET;
    logic [COUNT_BITS-1:0] bin_tally [MAX_BINS];
    logic [COUNT_BITS-1:0] counted_pixels = '0;

    bin_out_t expected_bins [$];
    bin_out_t fresh_bins [$];

    int  mismatches = 0;
    int  cycle_count = 0;
    bit  idling_on = 1'b0;
    bit  pix_gaps = 1'b0;

    plan_row_t plan_rows [PLAN_LEN] = '{
        // straight after reset: 8 bins over 0..255
        '{STEP_PIXEL,     9'd0,   1'b1, 1'b1, 6'd0,  17'd65536},
        '{STEP_PIXEL,     9'd255, 1'b1, 1'b1, 6'd7,  17'd65536},
        '{STEP_PIXEL,     9'd128, 1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd127, 1'b1, 1'b1, 6'd4,  17'd32768},
        // largest bin count
        '{STEP_SET_BINS,  9'd64,  1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd255, 1'b1, 1'b1, 6'd63, 17'd65536},
        // single bin
        '{STEP_SET_BINS,  9'd1,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd77,  1'b1, 1'b1, 6'd0,  17'd65536},
        // range of one: only pixel 0 is counted
        '{STEP_SET_RANGE, 9'd1,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd0,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd200, 1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd1,   1'b1, 1'b1, 6'd0,  17'd65536},
        // range end zero drops everything: empty image gives zero shares
        '{STEP_SET_RANGE, 9'd0,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd5,   1'b1, 1'b1, 6'd0,  17'd0},
        // bin count zero: no bins emitted, counts still cleared
        '{STEP_SET_BINS,  9'd0,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_SET_RANGE, 9'd256, 1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd9,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd10,  1'b1, 1'b0, 6'd0,  17'd0},
        // bin count above the maximum, range end above 256
        '{STEP_SET_BINS,  9'd127, 1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_SET_RANGE, 9'd511, 1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd255, 1'b1, 1'b1, 6'd31, 17'd65536},
        // three bins, pixels on both sides of the first bin edge
        '{STEP_SET_BINS,  9'd3,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_SET_RANGE, 9'd256, 1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd0,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd85,  1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd86,  1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd171, 1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd255, 1'b1, 1'b1, 6'd0,  17'd26214},
        // bin count cut mid-image: bin 7 stays in the total, is not emitted
        '{STEP_SET_BINS,  9'd8,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd255, 1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_SET_BINS,  9'd4,   1'b0, 1'b0, 6'd0,  17'd0},
        '{STEP_PIXEL,     9'd0,   1'b1, 1'b1, 6'd0,  17'd32768}
    };

    normalized_pixel_histogram #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .bin_valid (bin_valid),
        .bin_stall (bin_stall),
        .bin_data  (bin_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Print one line per mismatch (the first few only) and count them all.
    task automatic report_mismatch(input string msg);
        if (mismatches < 30)
        begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
        mismatches++;
    endtask

    // Sort one pixel into its bin and, on the last pixel, work out the
    // share of every bin in use. Shares land in fresh_bins.
    function automatic void predict_pixel(input pix_in_t item);
        int unsigned       nbins;
        int unsigned       bin;
        longint unsigned   share;
        bin_out_t          share_item;
        nbins = (bins_setting > BINS_W'(MAX_BINS)) ? MAX_BINS : int'(bins_setting);
        if (nbins != 0 && range_setting != 0)
        begin
            bin = (int'(item.pixel) * nbins) / int'(range_setting);
            if (bin < nbins)
            begin
                if (bin_tally[bin] != '1)
                    bin_tally[bin] = bin_tally[bin] + 1'b1;
                if (counted_pixels != '1)
                    counted_pixels = counted_pixels + 1'b1;
            end
        end
        if (item.last_pixel)
        begin
            for (int i = 0; i < nbins; i++)
            begin
                share = 0;
                if (counted_pixels != 0)
                    share = (longint'(bin_tally[i]) << FRAC_BITS) / longint'(counted_pixels);
                if (share > SHARE_ONE)
                    share = SHARE_ONE;
                share_item.bin_index = IDX_W'(i);
                share_item.bin_value = VAL_W'(share);
                share_item.last_bin  = (i + 1 == nbins);
                fresh_bins = {fresh_bins, share_item};
            end
            for (int i = 0; i < MAX_BINS; i++)
                bin_tally[i] = '0;
            counted_pixels = '0;
        end
    endfunction

    // Offer one pixel item, hold it until taken, then predict its bins.
    task automatic send_pixel(input pix_in_t item, input logic typed,
                              input logic [IDX_W-1:0] typed_bin,
                              input logic [VAL_W-1:0] typed_share);
        if (pix_gaps && $urandom_range(0, 4) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= item;
        do
            @(posedge clk);
        while (pix_stall);
        predict_pixel(item);
        foreach (fresh_bins[j])
        begin
            if (typed && fresh_bins[j].bin_index == typed_bin)
                fresh_bins[j].bin_value = typed_share;
            expected_bins = {expected_bins, fresh_bins[j]};
        end
        fresh_bins.delete();
    endtask

    // Drop valid and wait until every expected bin has come out and the
    // block has had time to finish any pixel that gives no result.
    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write a register while idle, then read it back.
    task automatic write_register(input logic reg_sel, input logic [8:0] value);
        logic [PDATA_W-1:0] readback;
        logic [PDATA_W-1:0] wanted;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // read phase reuses the select
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == REG_BIN_COUNT)
        begin
            bins_setting = value[BINS_W-1:0];
            wanted = PDATA_W'(value[BINS_W-1:0]);
        end
        else
        begin
            range_setting = value[RANGE_W-1:0];
            wanted = PDATA_W'(value[RANGE_W-1:0]);
        end
        if (readback != wanted)
            report_mismatch($sformatf("register %0d reads %0d, written %0d",
                                      reg_sel, readback, wanted));
    endtask

    function automatic logic [8:0] pick_bins();
        case ($urandom_range(0, 9))
            0: return 9'd1;
            1: return 9'd64;
            2: return 9'd0;
            3: return 9'($urandom_range(65, 127));
            default: return 9'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [8:0] pick_range();
        case ($urandom_range(0, 9))
            0: return 9'd1;
            1: return 9'd256;
            2: return 9'd0;
            3: return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(1, 256));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Check each bin item taken against the oldest expectation.
    always @(posedge clk)
    begin
        bin_out_t want;
        if (rst_n && bin_valid && !bin_stall)
        begin
            if (expected_bins.size() == 0)
            begin
                report_mismatch($sformatf("bin %0d value %0d with nothing expected",
                                          bin_data.bin_index, bin_data.bin_value));
            end
            else
            begin
                want = expected_bins.pop_front();
                if (bin_data.bin_index != want.bin_index)
                    report_mismatch($sformatf("bin_index %0d, expected %0d",
                                              bin_data.bin_index, want.bin_index));
                if (bin_data.bin_value != want.bin_value)
                    report_mismatch($sformatf("bin %0d bin_value %0d, expected %0d",
                                              want.bin_index, bin_data.bin_value,
                                              want.bin_value));
                if (bin_data.last_bin != want.last_bin)
                    report_mismatch($sformatf("bin %0d last_bin %0d, expected %0d",
                                              want.bin_index, bin_data.last_bin,
                                              want.last_bin));
            end
        end
    end

    // Receiver stalls in bursts, with quiet stretches now and then.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 63) == 0)
            begin
                repeat ($urandom_range(50, 150)) @(posedge clk);
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                bin_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                bin_stall <= 1'b0;
            end
        end
    end

    // Give up after a generous number of cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        plan_row_t  row;
        pix_in_t    item;
        int         sent;
        int         image_len;
        bit         cut_short;
        for (int i = 0; i < MAX_BINS; i++)
            bin_tally[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan, no idling on either side
        foreach (plan_rows[r])
        begin
            row = plan_rows[r];
            case (row.kind)
                STEP_SET_BINS:  write_register(REG_BIN_COUNT, row.value);
                STEP_SET_RANGE: write_register(REG_RANGE_END, row.value);
                default:
                begin
                    item.pixel      = row.value[PIX_W-1:0];
                    item.last_pixel = row.last;
                    send_pixel(item, row.typed, row.typed_bin, row.typed_share);
                end
            endcase
        end

        // random images; a few end without a last pixel so that the next
        // setting lands mid-image
        idling_on = 1'b1;
        sent = 0;
        write_register(REG_BIN_COUNT, pick_bins());
        write_register(REG_RANGE_END, pick_range());
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS)
                idling_on = 1'b0;
            if ($urandom_range(0, 2) == 0)
                write_register(REG_BIN_COUNT, pick_bins());
            if ($urandom_range(0, 3) == 0)
                write_register(REG_RANGE_END, pick_range());
            pix_gaps  = idling_on && ($urandom_range(0, 3) != 0);
            image_len = $urandom_range(1, 12);
            cut_short = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < image_len; k++)
            begin
                item.pixel      = pick_pixel();
                item.last_pixel = (k == image_len - 1) && !cut_short;
                send_pixel(item, 1'b0, '0, '0);
                sent++;
            end
        end

        // drain and let any trailing item show up
        wait_idle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* normalized_pixel_histogram.f */
src/nph_pkg.sv
src/nph_div.sv
src/normalized_pixel_histogram.sv
src/nph_chk.sv
bench/testbench.sv
